[rtl/core/hvn_pkg.sv]
package hvn_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_COLS = 3'd0,
        CFG_GRID_ROWS = 3'd1,
        CFG_SPAN_X    = 3'd2,
        CFG_SPAN_Y    = 3'd3,
        CFG_SPAN_Z    = 3'd4
    } cfg_index_t;

    localparam logic [7:0] RST_GRID_COLS = 8'd128;
    localparam logic [7:0] RST_GRID_ROWS = 8'd128;
    localparam logic [7:0] RST_SPAN_X    = 8'd50;
    localparam logic [7:0] RST_SPAN_Y    = 8'd10;
    localparam logic [7:0] RST_SPAN_Z    = 8'd50;

    localparam logic [15:0] NORMAL_ONE = 16'd16384;

endpackage

[rtl/core/hvn_ram.sv]
module hvn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/heightmap_vertex_normal_gen.sv]
// heightmap vertex and normal generator
// input channel (s_*): one request per item. a write (s_req_type low) stores
// s_height_sample at column/row; no result is returned.
// a read returns one result item on the m_* channel with the vertex position
// (unsigned Q8.8) and its unit normal (signed Q2.14). a read outside the grid
// in use gives no result and leaves the block idle.
// a read's result comes from nine height fetches from the single read port of
// the height memory, three multiply stages, a one-bit-a-cycle normalising
// shift, a 32-step square root and five 16-step divisions on one shared
// divider; when the normal sum is zero the square root is skipped. the next
// item is taken once the block is back in idle. one read is in flight at a
// time.
// the finished result sits in an output register; while the receiver stalls
// the block keeps accepting writes and starts the next read, which then holds
// at its final step until the waiting result is taken.
// reset (aresetn low, synchronous) returns the state and configuration registers
// to their defaults and drops any pending result; the height memory is not
// cleared and must be written before it is read.
// configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once and
// must be made only while the block is idle; the block does not enforce it.
module heightmap_vertex_normal_gen #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 128
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [hvn_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hvn_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_req_type,
    input  logic [6:0]                      s_grid_col,
    input  logic [6:0]                      s_grid_row,
    input  logic [7:0]                      s_height_sample,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [15:0]                     m_pos_x,
    output logic [15:0]                     m_pos_y,
    output logic [15:0]                     m_pos_z,
    output logic signed [15:0]              m_normal_x,
    output logic signed [15:0]              m_normal_y,
    output logic signed [15:0]              m_normal_z
);

    import hvn_pkg::*;

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE, ST_FETCH, ST_FWAIT, ST_SUMS, ST_MUL1, ST_MUL2, ST_MUL3,
        ST_SHIFT, ST_SQ, ST_SQRT, ST_DLOAD, ST_DRUN, ST_DONE
    } state_t;

    state_t state_reg;

    logic [7:0] grid_cols_reg, grid_rows_reg, span_x_reg, span_y_reg, span_z_reg;

    // datapath registers
    logic [6:0]         col_reg, row_reg;
    logic [1:0]         fr_reg, fc_reg;
    logic               rd_pend_reg;
    logic [3:0]         rd_idx_reg;
    logic [7:0]         g_reg [9];
    logic signed [11:0] sx_sum_reg, sz_sum_reg;
    logic [2:0]         tri_reg;
    logic [15:0]        pa_reg, pb_reg, pc_reg;
    logic [10:0]        ax_reg, az_reg;
    logic               neg_x_reg, neg_z_reg;
    logic [23:0]        qa_reg, qc_reg;
    logic [34:0]        m_reg [3];
    logic               zero_reg;
    logic [59:0]        prod_reg;
    logic [61:0]        acc_reg;
    logic [1:0]         sq_cnt_reg;
    logic [63:0]        v_reg, res_reg, bit_reg;
    logic [30:0]        r_reg;
    logic [2:0]         dop_reg;
    logic [46:0]        rem_reg, dsh_reg;
    logic [15:0]        quo_reg;
    logic [3:0]         it_reg;
    logic [15:0]        posx_res, posy_res, posz_res;
    logic [15:0]        nrm_res [3];
    logic               m_valid_reg;
    logic [15:0]        m_pos_x_reg, m_pos_y_reg, m_pos_z_reg;
    logic [15:0]        m_nx_reg, m_ny_reg, m_nz_reg;

    // clamped grid size
    logic [7:0] c_dim, r_dim, cm1, rm1;

    always_comb begin
        if (grid_cols_reg < 8'd2) begin
            c_dim = 8'd2;
        end else if (11'(grid_cols_reg) > 11'(MAX_COLS)) begin
            c_dim = 8'(MAX_COLS);
        end else begin
            c_dim = grid_cols_reg;
        end
        if (grid_rows_reg < 8'd2) begin
            r_dim = 8'd2;
        end else if (11'(grid_rows_reg) > 11'(MAX_ROWS)) begin
            r_dim = 8'(MAX_ROWS);
        end else begin
            r_dim = grid_rows_reg;
        end
        cm1 = c_dim - 8'd1;
        rm1 = r_dim - 8'd1;
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_cols_reg <= RST_GRID_COLS;
            grid_rows_reg <= RST_GRID_ROWS;
            span_x_reg    <= RST_SPAN_X;
            span_y_reg    <= RST_SPAN_Y;
            span_z_reg    <= RST_SPAN_Z;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_GRID_COLS: grid_cols_reg <= cfg_wdata;
                CFG_GRID_ROWS: grid_rows_reg <= cfg_wdata;
                CFG_SPAN_X:    span_x_reg    <= cfg_wdata;
                CFG_SPAN_Y:    span_y_reg    <= cfg_wdata;
                CFG_SPAN_Z:    span_z_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // height memory
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_rdata;

    assign s_ready = (state_reg == ST_IDLE);

    assign ram_we = s_valid && s_ready && (s_req_type == REQ_WRITE)
                    && (11'(s_grid_col) < 11'(MAX_COLS))
                    && (11'(s_grid_row) < 11'(MAX_ROWS));
    assign ram_waddr = AW'(int'(s_grid_row) * MAX_COLS + int'(s_grid_col));

    logic [10:0] f_rr, f_cc;
    logic        f_ok;

    always_comb begin
        // neighbour at (row-1+fr, col-1+fc); off-grid positions read entry zero
        f_rr = 11'(row_reg) + 11'(fr_reg);
        f_cc = 11'(col_reg) + 11'(fc_reg);
        f_ok = (f_rr != 11'd0) && (f_rr <= 11'(MAX_ROWS))
               && (f_cc != 11'd0) && (f_cc <= 11'(MAX_COLS));
        if (f_ok) begin
            ram_raddr = AW'(int'(f_rr - 11'd1) * MAX_COLS + int'(f_cc - 11'd1));
        end else begin
            ram_raddr = '0;
        end
    end

    hvn_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_height_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_height_sample),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // height differences over the adjacent triangles
    logic signed [11:0] gs [9];
    logic signed [11:0] sx_sum, sz_sum;
    logic               v00, v10, v01, v11;
    logic [2:0]         tri_cnt;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            gs[k] = {4'b0, g_reg[k]};
        end
        v00 = (row_reg != 7'd0) && (col_reg != 7'd0);
        v10 = (({1'b0, row_reg} + 8'd1) < r_dim) && (col_reg != 7'd0);
        v01 = (row_reg != 7'd0) && (({1'b0, col_reg} + 8'd1) < c_dim);
        v11 = (({1'b0, row_reg} + 8'd1) < r_dim) && (({1'b0, col_reg} + 8'd1) < c_dim);
        sx_sum = '0;
        sz_sum = '0;
        if (v00) begin
            sx_sum = sx_sum + (gs[0] - gs[1]) + (gs[3] - gs[4]);
            sz_sum = sz_sum + (gs[1] - gs[4]) + (gs[0] - gs[3]);
        end
        if (v10) begin
            sx_sum = sx_sum + (gs[3] - gs[4]);
            sz_sum = sz_sum + (gs[4] - gs[7]);
        end
        if (v01) begin
            sx_sum = sx_sum + (gs[4] - gs[5]);
            sz_sum = sz_sum + (gs[1] - gs[4]);
        end
        if (v11) begin
            sx_sum = sx_sum + (gs[4] - gs[5]) + (gs[7] - gs[8]);
            sz_sum = sz_sum + (gs[5] - gs[8]) + (gs[4] - gs[7]);
        end
        tri_cnt = {v00, 1'b0} + {2'b0, v10} + {2'b0, v01} + {v11, 1'b0};
    end

    // largest magnitude for the normalising shift
    logic [34:0] big;

    always_comb begin
        big = m_reg[0];
        if (m_reg[1] > big) begin
            big = m_reg[1];
        end
        if (m_reg[2] > big) begin
            big = m_reg[2];
        end
    end

    logic [29:0] sq_sel;
    assign sq_sel = (sq_cnt_reg != 2'd3) ? m_reg[sq_cnt_reg][29:0] : 30'd0;

    // square root step
    logic [63:0] sr_trial, sr_res_next, sr_v_next;

    always_comb begin
        sr_trial = res_reg + bit_reg;
        if (v_reg >= sr_trial) begin
            sr_v_next   = v_reg - sr_trial;
            sr_res_next = (res_reg >> 1) + bit_reg;
        end else begin
            sr_v_next   = v_reg;
            sr_res_next = res_reg >> 1;
        end
    end

    // divider operands and step
    logic [46:0] d_num;
    logic [30:0] d_den;
    logic [1:0]  d_mi;
    logic [15:0] quo_next;
    logic [15:0] q_clamp, q_signed;
    logic        q_neg;

    always_comb begin
        d_mi = 2'(dop_reg - 3'd2);
        case (dop_reg) inside
            3'd0: begin
                d_num = {23'b0, 15'(col_reg) * 15'(span_x_reg), 9'b0} + 47'(cm1);
                d_den = 31'({cm1, 1'b0});
            end
            3'd1: begin
                d_num = {23'b0, 15'(row_reg) * 15'(span_z_reg), 9'b0} + 47'(rm1);
                d_den = 31'({rm1, 1'b0});
            end
            [3'd2:3'd4]: begin
                d_num = 47'({m_reg[d_mi][29:0], 14'b0}) + 47'(r_reg >> 1);
                d_den = r_reg;
            end
            default: begin
                d_num = '0;
                d_den = '0;
            end
        endcase
        quo_next = (rem_reg >= dsh_reg) ? {quo_reg[14:0], 1'b1} : {quo_reg[14:0], 1'b0};
        q_clamp  = (quo_next > NORMAL_ONE) ? NORMAL_ONE : quo_next;
        q_neg    = (d_mi == 2'd0) ? neg_x_reg : ((d_mi == 2'd2) ? neg_z_reg : 1'b0);
        q_signed = q_neg ? (16'd0 - q_clamp) : q_clamp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= (state_reg == ST_FETCH);
            if (rd_pend_reg) begin
                g_reg[rd_idx_reg] <= ram_rdata;
            end
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_req_type == REQ_READ) begin
                        col_reg <= s_grid_col;
                        row_reg <= s_grid_row;
                        fr_reg  <= 2'd0;
                        fc_reg  <= 2'd0;
                        if (({1'b0, s_grid_col} < c_dim) && ({1'b0, s_grid_row} < r_dim)) begin
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                ST_FETCH: begin
                    rd_idx_reg <= 4'({2'b0, fr_reg} * 4'd3 + {2'b0, fc_reg});
                    if (fc_reg == 2'd2) begin
                        fc_reg <= 2'd0;
                        fr_reg <= fr_reg + 2'd1;
                        if (fr_reg == 2'd2) begin
                            state_reg <= ST_FWAIT;
                        end
                    end else begin
                        fc_reg <= fc_reg + 2'd1;
                    end
                end
                ST_FWAIT: begin
                    state_reg <= ST_SUMS;
                end
                ST_SUMS: begin
                    sx_sum_reg <= sx_sum;
                    sz_sum_reg <= sz_sum;
                    tri_reg    <= tri_cnt;
                    posy_res   <= 16'(g_reg[4]) * 16'(span_y_reg);
                    state_reg  <= ST_MUL1;
                end
                ST_MUL1: begin
                    pa_reg    <= 16'(span_z_reg) * 16'(span_y_reg);
                    pb_reg    <= 16'(span_x_reg) * 16'(span_z_reg);
                    pc_reg    <= 16'(span_x_reg) * 16'(span_y_reg);
                    ax_reg    <= sx_sum_reg[11] ? 11'(-sx_sum_reg) : sx_sum_reg[10:0];
                    az_reg    <= sz_sum_reg[11] ? 11'(-sz_sum_reg) : sz_sum_reg[10:0];
                    neg_x_reg <= sx_sum_reg[11];
                    neg_z_reg <= sz_sum_reg[11];
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    qa_reg    <= 24'(pa_reg) * 24'(cm1);
                    qc_reg    <= 24'(pc_reg) * 24'(rm1);
                    m_reg[1]  <= (35'(pb_reg) * 35'(tri_reg)) << 8;
                    state_reg <= ST_MUL3;
                end
                ST_MUL3: begin
                    m_reg[0]  <= 35'(qa_reg) * 35'(ax_reg);
                    m_reg[2]  <= 35'(qc_reg) * 35'(az_reg);
                    state_reg <= ST_SHIFT;
                end
                ST_SHIFT: begin
                    if (big == 35'd0) begin
                        zero_reg  <= 1'b1;
                        dop_reg   <= 3'd0;
                        state_reg <= ST_DLOAD;
                    end else if (big[34:30] != 5'd0) begin
                        for (int k = 0; k < 3; k++) begin
                            m_reg[k] <= m_reg[k] >> 1;
                        end
                    end else if (!big[29]) begin
                        for (int k = 0; k < 3; k++) begin
                            m_reg[k] <= m_reg[k] << 1;
                        end
                    end else begin
                        zero_reg   <= 1'b0;
                        sq_cnt_reg <= 2'd0;
                        acc_reg    <= '0;
                        state_reg  <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    // squares are registered before they are summed
                    if (sq_cnt_reg != 2'd3) begin
                        prod_reg <= 60'(sq_sel) * 60'(sq_sel);
                    end
                    if (sq_cnt_reg != 2'd0) begin
                        acc_reg <= acc_reg + 62'(prod_reg);
                    end
                    sq_cnt_reg <= sq_cnt_reg + 2'd1;
                    if (sq_cnt_reg == 2'd3) begin
                        v_reg     <= 64'(acc_reg) + 64'(prod_reg);
                        res_reg   <= '0;
                        bit_reg   <= 64'd1 << 62;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    v_reg   <= sr_v_next;
                    res_reg <= sr_res_next;
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg == 64'd1) begin
                        r_reg     <= sr_res_next[30:0];
                        dop_reg   <= 3'd0;
                        state_reg <= ST_DLOAD;
                    end
                end
                ST_DLOAD: begin
                    rem_reg   <= d_num;
                    dsh_reg   <= 47'(d_den) << 15;
                    quo_reg   <= '0;
                    it_reg    <= '0;
                    state_reg <= ST_DRUN;
                end
                ST_DRUN: begin
                    if (rem_reg >= dsh_reg) begin
                        rem_reg <= rem_reg - dsh_reg;
                    end
                    quo_reg <= quo_next;
                    dsh_reg <= dsh_reg >> 1;
                    it_reg  <= it_reg + 4'd1;
                    if (it_reg == 4'd15) begin
                        case (dop_reg) inside
                            3'd0: posx_res <= quo_next;
                            3'd1: posz_res <= quo_next;
                            [3'd2:3'd4]: nrm_res[d_mi] <= zero_reg ? 16'd0 : q_signed;
                            default: ;
                        endcase
                        if (dop_reg == 3'd4) begin
                            state_reg <= ST_DONE;
                        end else begin
                            dop_reg   <= dop_reg + 3'd1;
                            state_reg <= ST_DLOAD;
                        end
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_pos_x_reg <= posx_res;
                        m_pos_y_reg <= posy_res;
                        m_pos_z_reg <= posz_res;
                        m_nx_reg    <= nrm_res[0];
                        m_ny_reg    <= nrm_res[1];
                        m_nz_reg    <= nrm_res[2];
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_pos_x    = m_pos_x_reg;
    assign m_pos_y    = m_pos_y_reg;
    assign m_pos_z    = m_pos_z_reg;
    assign m_normal_x = m_nx_reg;
    assign m_normal_y = m_ny_reg;
    assign m_normal_z = m_nz_reg;

    // the memory is only written while no read is being worked on
    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_IDLE))
        else $error("height written during a read");

    // the shift loop leaves the largest magnitude in [2^29, 2^30)
    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQ && sq_cnt_reg == 2'd0) |-> (big[34:29] == 6'd1))
        else $error("normalising shift out of range");

    // a result appears only from the final step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside final step");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(m_pos_x_reg) && $stable(m_nx_reg))
        else $error("pending result overwritten");

endmodule

[tb/heightmap_vertex_normal_gen_tb.sv]
`timescale 1ns / 1ps

module heightmap_vertex_normal_gen_tb;
    import hvn_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 250;
    localparam int HOLD_CYCLES    = 400;
    localparam int GRID_MAX       = 128;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd5;

    typedef struct packed {
        logic [15:0]        pos_x;
        logic [15:0]        pos_y;
        logic [15:0]        pos_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } vertex_t;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [7:0]           reg_val;
        logic                 req;
        logic [6:0]           col;
        logic [6:0]           row;
        logic [7:0]           height;
        bit                   typed;
        vertex_t              want;
    } step_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_req_type = 1'b0;
    logic [6:0] s_grid_col = '0;
    logic [6:0] s_grid_row = '0;
    logic [7:0] s_height_sample = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [15:0] m_pos_x, m_pos_y, m_pos_z;
    logic signed [15:0] m_normal_x, m_normal_y, m_normal_z;

    heightmap_vertex_normal_gen u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_grid_col(s_grid_col), .s_grid_row(s_grid_row),
        .s_height_sample(s_height_sample),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pos_x(m_pos_x), .m_pos_y(m_pos_y), .m_pos_z(m_pos_z),
        .m_normal_x(m_normal_x), .m_normal_y(m_normal_y), .m_normal_z(m_normal_z)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // shadow of the block's state
    logic [7:0] height_shadow [GRID_MAX*GRID_MAX];
    bit         height_known  [GRID_MAX*GRID_MAX];
    int unsigned cols_reg, rows_reg, span_x_reg, span_y_reg, span_z_reg;

    vertex_t   pending_vertices[$];
    step_row_t directed_steps[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;
    bit  hold_go = 1'b0;
    bit  hold_used = 1'b0;
    int  hold_left = 0;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, cand;
        res = 0;
        for (int b = 31; b >= 0; b--) begin
            cand = res | (64'd1 << b);
            if (cand * cand <= v) res = cand;
        end
        return res;
    endfunction

    function automatic longint height_at(input longint r, input longint c);
        return longint'(height_shadow[r*GRID_MAX + c]);
    endfunction

    // returns 0 where the read falls outside the grid in use
    function automatic bit predict_vertex(input longint col, input longint row,
                                          output vertex_t v);
        longint ncols, nrows, sx, sy, sz, diff_x, diff_z, tris, ti, tj;
        longint nvec [3];
        longint unsigned mag [3];
        longint unsigned big, sumsq, root, q;
        bit in_a, in_b;
        v = '0;
        ncols = cols_reg < 2 ? 2 : (cols_reg > GRID_MAX ? GRID_MAX : cols_reg);
        nrows = rows_reg < 2 ? 2 : (rows_reg > GRID_MAX ? GRID_MAX : rows_reg);
        if (col >= ncols || row >= nrows) return 1'b0;
        sx = span_x_reg; sy = span_y_reg; sz = span_z_reg;
        v.pos_x = 16'((2*col*sx*256 + (ncols-1)) / (2*(ncols-1)));
        v.pos_y = 16'(height_at(row, col) * sy);
        v.pos_z = 16'((2*row*sz*256 + (nrows-1)) / (2*(nrows-1)));
        diff_x = 0; diff_z = 0; tris = 0;
        for (int dr = 0; dr < 2; dr++) begin
            for (int dc = 0; dc < 2; dc++) begin
                ti = row - 1 + dr;
                tj = col - 1 + dc;
                if (ti < 0 || tj < 0 || ti > nrows-2 || tj > ncols-2) continue;
                in_a = (row == ti+1 && col == tj+1) || (row == ti && col == tj+1) ||
                       (row == ti && col == tj);
                in_b = (row == ti && col == tj) || (row == ti+1 && col == tj) ||
                       (row == ti+1 && col == tj+1);
                if (in_a) begin
                    diff_x += height_at(ti, tj) - height_at(ti, tj+1);
                    diff_z += height_at(ti, tj+1) - height_at(ti+1, tj+1);
                    tris++;
                end
                if (in_b) begin
                    diff_x += height_at(ti+1, tj) - height_at(ti+1, tj+1);
                    diff_z += height_at(ti, tj) - height_at(ti+1, tj);
                    tris++;
                end
            end
        end
        nvec[0] = sz * sy * (ncols-1) * diff_x;
        nvec[1] = 256 * sx * sz * tris;
        nvec[2] = sx * sy * (nrows-1) * diff_z;
        big = 0;
        for (int k = 0; k < 3; k++) begin
            mag[k] = nvec[k] < 0 ? longint'(-nvec[k]) : nvec[k];
            if (mag[k] > big) big = mag[k];
        end
        if (big == 0) return 1'b1;
        // bring the largest magnitude into [2^29, 2^30)
        while (big >= (64'd1 << 30)) begin
            big >>= 1;
            for (int k = 0; k < 3; k++) mag[k] >>= 1;
        end
        while (big < (64'd1 << 29)) begin
            big <<= 1;
            for (int k = 0; k < 3; k++) mag[k] <<= 1;
        end
        sumsq = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
        root = int_sqrt(sumsq);
        for (int k = 0; k < 3; k++) begin
            q = ((mag[k] << 14) + (root >> 1)) / root;
            if (q > 16384) q = 16384;
            if (nvec[k] < 0) q = -q;
            case (k)
                0: v.normal_x = 16'(q);
                1: v.normal_y = 16'(q);
                default: v.normal_z = 16'(q);
            endcase
        end
        return 1'b1;
    endfunction

    task automatic send_item(input logic req, input logic [6:0] col, input logic [6:0] row,
                             input logic [7:0] h, input bit typed, input vertex_t want);
        vertex_t v;
        bit has;
        if (!calm) begin
            while ($urandom_range(99) < 21) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid         <= 1'b1;
        s_req_type      <= req;
        s_grid_col      <= col;
        s_grid_row      <= row;
        s_height_sample <= h;
        do @(posedge aclk); while (!s_ready);
        if (req == REQ_WRITE) begin
            height_shadow[row*GRID_MAX + col] = h;
            height_known[row*GRID_MAX + col]  = 1'b1;
        end else begin
            has = predict_vertex(col, row, v);
            if (has) pending_vertices.push_back(typed ? want : v);
        end
    endtask

    // every neighbour the block may fetch is written before the read goes out
    task automatic issue_read(input int col, input int row, input bit typed,
                              input vertex_t want);
        for (int r = row-1; r <= row+1; r++) begin
            for (int c = col-1; c <= col+1; c++) begin
                if (r < 0 || c < 0 || r >= GRID_MAX || c >= GRID_MAX) continue;
                if (!height_known[r*GRID_MAX + c])
                    send_item(REQ_WRITE, 7'(c), 7'(r), 8'($urandom_range(255)), 1'b0, '0);
            end
        end
        send_item(REQ_READ, 7'(col), 7'(row), 8'($urandom_range(255)), typed, want);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_GRID_COLS: cols_reg   = val;
            CFG_GRID_ROWS: rows_reg   = val;
            CFG_SPAN_X:    span_x_reg = val;
            CFG_SPAN_Y:    span_y_reg = val;
            CFG_SPAN_Z:    span_z_reg = val;
            default: ;
        endcase
    endtask

    task automatic set_grid(input int c, input int r, input int sx, input int sy,
                            input int sz);
        write_reg(CFG_GRID_COLS, 8'(c));
        write_reg(CFG_GRID_ROWS, 8'(r));
        write_reg(CFG_SPAN_X, 8'(sx));
        write_reg(CFG_SPAN_Y, 8'(sy));
        write_reg(CFG_SPAN_Z, 8'(sz));
        cfg_we <= 1'b0;
    endtask

    function automatic void add_item(input logic req, input int col, input int row,
                                     input int h, input bit typed, input vertex_t want);
        step_row_t s;
        s = '{default: '0};
        s.req = req; s.col = 7'(col); s.row = 7'(row); s.height = 8'(h);
        s.typed = typed; s.want = want;
        directed_steps.push_back(s);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input int val);
        step_row_t s;
        s = '{default: '0};
        s.is_cfg = 1'b1; s.reg_idx = idx; s.reg_val = 8'(val);
        directed_steps.push_back(s);
    endfunction

    // receiver: random back-pressure plus one long hold-off
    always @(posedge aclk) begin
        if (hold_go && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 21);
        end
    end

    // result checker and watchdog
    always @(posedge aclk) begin
        vertex_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_pos_x, m_pos_y, m_pos_z, m_normal_x, m_normal_y, m_normal_z};
            if (pending_vertices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected vertex item %p", got);
            end else begin
                want = pending_vertices.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("vertex mismatch: expected %p, got %p", want, got);
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        vertex_t flat_low, flat_high;
        int ncols, nrows, budget, pick;
        foreach (height_known[i]) height_known[i] = 1'b0;
        cols_reg = RST_GRID_COLS; rows_reg = RST_GRID_ROWS;
        span_x_reg = RST_SPAN_X; span_y_reg = RST_SPAN_Y; span_z_reg = RST_SPAN_Z;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // flat corners after reset: normal points straight up
        flat_low  = '{16'd0, 16'd0, 16'd0, 16'sd0, 16'sd16384, 16'sd0};
        flat_high = '{16'd12800, 16'd2550, 16'd12800, 16'sd0, 16'sd16384, 16'sd0};
        for (int r = 0; r < 2; r++)
            for (int c = 0; c < 2; c++) add_item(REQ_WRITE, c, r, 0, 1'b0, '0);
        add_item(REQ_READ, 0, 0, 255, 1'b1, flat_low);
        for (int r = 126; r < 128; r++)
            for (int c = 126; c < 128; c++) add_item(REQ_WRITE, c, r, 255, 1'b0, '0);
        add_item(REQ_READ, 127, 127, 0, 1'b1, flat_high);
        add_item(REQ_WRITE, 1, 0, 200, 1'b0, '0);
        add_item(REQ_READ, 0, 0, 0, 1'b0, '0);
        add_item(REQ_READ, 1, 1, 0, 1'b0, '0);
        add_cfg(CFG_GRID_COLS, 3);
        add_cfg(CFG_GRID_ROWS, 2);
        add_cfg(CFG_IDX_SPARE, 77);
        add_item(REQ_READ, 5, 0, 0, 1'b0, '0);
        add_item(REQ_READ, 0, 2, 0, 1'b0, '0);
        add_item(REQ_READ, 2, 1, 0, 1'b0, '0);
        add_cfg(CFG_SPAN_X, 0);
        add_cfg(CFG_SPAN_Y, 0);
        add_item(REQ_READ, 1, 0, 0, 1'b0, '0);

        foreach (directed_steps[i]) begin
            if (directed_steps[i].is_cfg) begin
                drain_results();
                write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
                cfg_we <= 1'b0;
            end else if (directed_steps[i].req == REQ_READ) begin
                issue_read(directed_steps[i].col, directed_steps[i].row,
                           directed_steps[i].typed, directed_steps[i].want);
            end else begin
                send_item(REQ_WRITE, directed_steps[i].col, directed_steps[i].row,
                          directed_steps[i].height, 1'b0, '0);
            end
        end

        for (int ph = 0; ph < 11; ph++) begin
            drain_results();
            calm = 1'b0;
            case (ph)
                0: set_grid(2, 2, 255, 255, 255);
                1: set_grid(0, 255, 0, 0, 1);
                2: begin
                    set_grid(128, 128, 1, 255, 255);
                    calm    = 1'b1;
                    hold_go <= 1'b1;
                end
                3: set_grid(1, 3, 255, 0, 1);
                4: set_grid(128, 128, 255, 255, 255);
                default: set_grid($urandom_range(2, 20), $urandom_range(2, 20),
                                  $urandom_range(255), $urandom_range(255),
                                  $urandom_range(255));
            endcase
            ncols = cols_reg < 2 ? 2 : (cols_reg > GRID_MAX ? GRID_MAX : cols_reg);
            nrows = rows_reg < 2 ? 2 : (rows_reg > GRID_MAX ? GRID_MAX : rows_reg);
            budget = 20;
            while (budget > 0) begin
                pick = $urandom_range(99);
                if (pick < 20) begin
                    send_item(REQ_WRITE, 7'($urandom_range(127)), 7'($urandom_range(127)),
                              8'($urandom_range(255)), 1'b0, '0);
                end else if (pick < 28 && (ncols < GRID_MAX || nrows < GRID_MAX)) begin
                    // read off the grid in use, no item comes back
                    if (ncols < GRID_MAX && (nrows == GRID_MAX || $urandom_range(1)))
                        send_item(REQ_READ, 7'($urandom_range(127, ncols)),
                                  7'($urandom_range(127)), 8'($urandom_range(255)),
                                  1'b0, '0);
                    else
                        send_item(REQ_READ, 7'($urandom_range(127)),
                                  7'($urandom_range(127, nrows)), 8'($urandom_range(255)),
                                  1'b0, '0);
                end else begin
                    issue_read($urandom_range(ncols-1), $urandom_range(nrows-1), 1'b0, '0);
                end
                budget--;
            end
        end

        drain_results();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/hvn_pkg.sv
rtl/core/hvn_ram.sv
rtl/core/heightmap_vertex_normal_gen.sv
tb/heightmap_vertex_normal_gen_tb.sv
